// ===== design/humidity_temp_frame_decoder_top_assert.svh =====
// assertion macros for the humidity and temperature frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH

// clocked property, off while reset is applied
`define HTFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define HTFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`HTFD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/htfd_pkg.sv =====
// shared types, constants and crc function for the frame decoder
`timescale 1ns / 1ps
`default_nettype none
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_SEED = 8'hFF;

	// byte position within a frame, idle waits for a frame start
	typedef enum logic [6:0] {
		POS0     = 7'b0000001,
		POS1     = 7'b0000010,
		POS2     = 7'b0000100,
		POS3     = 7'b0001000,
		POS4     = 7'b0010000,
		POS5     = 7'b0100000,
		POS_IDLE = 7'b1000000
	} pos_t;

	// decoded frame handed to the scaling stage
	typedef struct packed {
		logic        ok;
		logic [15:0] temp_word;
		logic [15:0] hum_word;
	} frame_t;

	// msb-first crc-8 over one byte, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
			else c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/htfd_frame.sv =====
// frame sequencing, word capture and crc checking
`timescale 1ns / 1ps
`default_nettype none
module htfd_frame
	import htfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	output logic            res_valid,
	output frame_t          res
);

	pos_t        pos_q, pos_eff, pos_d;
	logic [7:0]  crc_q, crc_eff, crc_d;
	logic [15:0] temp_q, temp_d;
	logic [15:0] hum_q, hum_d;
	logic        good_q, good_d;

	always_comb begin
		// a start mark always restarts the frame
		pos_eff   = frame_start ? POS0 : pos_q;
		crc_eff   = frame_start ? CRC_SEED : crc_q;
		pos_d     = pos_q;
		crc_d     = crc_eff;
		temp_d    = temp_q;
		hum_d     = hum_q;
		good_d    = good_q;
		res_valid = 1'b0;
		res.ok        = 1'b0;
		res.temp_word = temp_q;
		res.hum_word  = hum_q;
		unique case (pos_eff)
			POS0: begin
				temp_d = {rx_byte, 8'h00};
				crc_d  = crc8_update(crc_eff, rx_byte);
				pos_d  = POS1;
			end
			POS1: begin
				temp_d = {temp_q[15:8], rx_byte};
				crc_d  = crc8_update(crc_eff, rx_byte);
				pos_d  = POS2;
			end
			POS2: begin
				good_d = (crc_eff == rx_byte);
				crc_d  = CRC_SEED;
				pos_d  = POS3;
			end
			POS3: begin
				hum_d = {rx_byte, 8'h00};
				crc_d = crc8_update(crc_eff, rx_byte);
				pos_d = POS4;
			end
			POS4: begin
				hum_d = {hum_q[15:8], rx_byte};
				crc_d = crc8_update(crc_eff, rx_byte);
				pos_d = POS5;
			end
			POS5: begin
				res_valid = 1'b1;
				res.ok    = good_q && (crc_eff == rx_byte);
				crc_d     = CRC_SEED;
				pos_d     = POS_IDLE;
			end
			default: begin
				pos_d = POS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_IDLE;
			crc_q  <= CRC_SEED;
			temp_q <= '0;
			hum_q  <= '0;
			good_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_d;
			crc_q  <= crc_d;
			temp_q <= temp_d;
			hum_q  <= hum_d;
			good_q <= good_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/htfd_scale.sv =====
// conversion of raw words to milli-degrees and milli-percent
`timescale 1ns / 1ps
`default_nettype none
module htfd_scale
	import htfd_pkg::*;
(
	input  wire frame_t        frame,
	output logic signed [17:0] temp_milli_c,
	output logic        [16:0] rh_milli_pct
);

	localparam logic [14:0] TEMP_GAIN   = 15'd21875;
	localparam logic [13:0] HUM_GAIN    = 14'd12500;
	localparam logic [17:0] TEMP_OFFSET = 18'd45000;

	logic [30:0] temp_prod;
	logic [29:0] hum_prod;
	logic [17:0] temp_raw;

	assign temp_prod = {15'd0, frame.temp_word} * {16'd0, TEMP_GAIN};
	assign hum_prod  = {14'd0, frame.hum_word} * {16'd0, HUM_GAIN};
	// wraps modulo 2^18, which gives the two's complement result
	assign temp_raw  = temp_prod[30:13] - TEMP_OFFSET;

	assign temp_milli_c = frame.ok ? $signed(temp_raw) : 18'sd0;
	assign rh_milli_pct = frame.ok ? hum_prod[29:13] : 17'd0;

endmodule
`default_nettype wire

// ===== design/humidity_temp_frame_decoder_top.sv =====
// Frame decoder for a six-byte humidity/temperature measurement read. One byte
// transfer is taken per cycle, sustained; byte_ready drops only when the result
// stages are full and the result transfer is held off. A byte marked with
// frame_start begins a frame (temperature word, its crc, humidity word, its crc;
// crc-8, polynomial 0x31, seed 0xff); the sixth byte yields one result through
// the input register, crc check stage and scaling multiply into the result
// register. On any crc mismatch crc_ok is low and both values read zero. Bytes
// outside a frame give no result.
`timescale 1ns / 1ps
`default_nettype none
module humidity_temp_frame_decoder_top
	import htfd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          frame_start,
	output logic               result_valid,
	input  wire logic          result_ready,
	output logic signed [17:0] temp_milli_c,
	output logic        [16:0] rh_milli_pct,
	output logic               crc_ok
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              valid_s2;
	frame_t            frame_s2;
	logic              out_en, s2_en;
	logic              frm_valid;
	frame_t            frm_res;
	logic signed [17:0] temp_calc;
	logic        [16:0] rh_calc;
	logic              result_valid_q;
	logic signed [17:0] temp_q;
	logic        [16:0] rh_q;
	logic              ok_q;

	assign out_en     = !result_valid_q || result_ready;
	assign s2_en      = !valid_s2 || out_en;
	assign byte_ready = !valid_s1 || s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	htfd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && s2_en),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.res_valid   (frm_valid),
		.res         (frm_res)
	);

	// only the sixth byte of a frame moves on past this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= valid_s1 && frm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1 && frm_valid) begin
			frame_s2 <= frm_res;
		end
	end

	htfd_scale u_scale (
		.frame        (frame_s2),
		.temp_milli_c (temp_calc),
		.rh_milli_pct (rh_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_en) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			temp_q <= temp_calc;
			rh_q   <= rh_calc;
			ok_q   <= frame_s2.ok;
		end
	end

	assign result_valid = result_valid_q;
	assign temp_milli_c = temp_q;
	assign rh_milli_pct = rh_q;
	assign crc_ok       = ok_q;

endmodule
`default_nettype wire

// ===== design/htfd_checker.sv =====
// port-level checks for the frame decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_top_assert.svh"
module htfd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic signed [17:0] temp_milli_c,
	input wire logic        [16:0] rh_milli_pct,
	input wire logic               crc_ok
);

	// a stalled result must stay offered
	`HTFD_ASSERT(a_result_held, (result_valid && !result_ready) |=> result_valid,
		"result dropped before transfer")
	// failed crc reads as zero values
	`HTFD_ASSERT_IMPLY(a_fail_zero, result_valid && !crc_ok,
		(temp_milli_c == 18'sd0) && (rh_milli_pct == 17'd0), "nonzero values on crc failure")
	`HTFD_ASSERT_IMPLY(a_rh_range, result_valid && crc_ok, rh_milli_pct <= 17'd99998,
		"humidity out of range")
	`HTFD_ASSERT_IMPLY(a_temp_range, result_valid && crc_ok,
		(temp_milli_c >= -18'sd45000) && (temp_milli_c <= 18'sd129997),
		"temperature out of range")

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.temp_milli_c (temp_milli_c),
	.rh_milli_pct (rh_milli_pct),
	.crc_ok       (crc_ok)
);
`default_nettype wire

// ===== sim/humidity_temp_frame_decoder_top_tb.sv =====
// testbench for the humidity and temperature frame decoder with a crc-checking scoreboard
`timescale 1ns / 1ps
module humidity_temp_frame_decoder_top_tb;
	import htfd_pkg::*;

	typedef struct packed {
		logic signed [17:0] temp;
		logic        [16:0] rh;
		logic               ok;
	} reading_t;

	// tracks the frame in flight and the readings still owed by the block
	class frame_scoreboard;
		pos_t       frame_pos;
		logic [7:0] crc_acc;
		logic [15:0] t_word;
		logic [15:0] h_word;
		logic       t_crc_good;
		reading_t   readings_due[$];
		int         errors;
		int         good_frames;
		int         bad_frames;

		function new();
			frame_pos = POS_IDLE;
			crc_acc = CRC_SEED;
			t_word = '0;
			h_word = '0;
			t_crc_good = 1'b0;
			errors = 0;
			good_frames = 0;
			bad_frames = 0;
		endfunction

		// bit-serial form of the crc-8 update
		function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ d[i];
				c = {c[6:0], 1'b0};
				if (fb) c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function logic [7:0] crc_of_word(logic [15:0] w);
			return crc_step(crc_step(CRC_SEED, w[15:8]), w[7:0]);
		endfunction

		function int pending();
			return readings_due.size();
		endfunction

		function void note_byte(logic [7:0] d, logic start);
			pos_t        p;
			reading_t    r;
			logic [31:0] tq;
			logic [31:0] hq;
			logic        good;
			p = frame_pos;
			// a start mark always restarts, dropping any partial frame
			if (start) begin
				p = POS0;
				crc_acc = CRC_SEED;
			end
			case (p)
				POS0: begin
					t_word = {d, 8'h00};
					crc_acc = crc_step(crc_acc, d);
					frame_pos = POS1;
				end
				POS1: begin
					t_word[7:0] = d;
					crc_acc = crc_step(crc_acc, d);
					frame_pos = POS2;
				end
				POS2: begin
					t_crc_good = (crc_acc == d);
					crc_acc = CRC_SEED;
					frame_pos = POS3;
				end
				POS3: begin
					h_word = {d, 8'h00};
					crc_acc = crc_step(crc_acc, d);
					frame_pos = POS4;
				end
				POS4: begin
					h_word[7:0] = d;
					crc_acc = crc_step(crc_acc, d);
					frame_pos = POS5;
				end
				POS5: begin
					good = t_crc_good && (crc_acc == d);
					tq = '0;
					hq = '0;
					if (good) begin
						tq = ((32'd21875 * {16'd0, t_word}) >> 13) - 32'd45000;
						hq = (32'd12500 * {16'd0, h_word}) >> 13;
						good_frames++;
					end else begin
						bad_frames++;
					end
					r.temp = tq[17:0];
					r.rh = hq[16:0];
					r.ok = good;
					readings_due.push_back(r);
					crc_acc = CRC_SEED;
					frame_pos = POS_IDLE;
				end
				default: frame_pos = POS_IDLE;
			endcase
		endfunction

		function void check_result(logic signed [17:0] t, logic [16:0] h, logic ok);
			reading_t e;
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected result temp %0d rh %0d crc_ok %0b", $time, t, h, ok);
				errors++;
				return;
			end
			e = readings_due.pop_front();
			if (t !== e.temp) begin
				$display("%0t: temp_milli_c expected %0d got %0d", $time, e.temp, t);
				errors++;
			end
			if (h !== e.rh) begin
				$display("%0t: rh_milli_pct expected %0d got %0d", $time, e.rh, h);
				errors++;
			end
			if (ok !== e.ok) begin
				$display("%0t: crc_ok expected %0b got %0b", $time, e.ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	logic [7:0]         rx_byte = '0;
	logic               frame_start = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [17:0] temp_milli_c;
	logic        [16:0] rh_milli_pct;
	logic               crc_ok;

	frame_scoreboard sb = new();
	int src_idle_pct = 6;
	int dst_idle_pct = 78;
	int stall_requests = 0;
	int stall_served = 0;
	int stall_left = 0;
	int byte_transfers = 0;

	humidity_temp_frame_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.rx_byte(rx_byte),
		.frame_start(frame_start),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.temp_milli_c(temp_milli_c),
		.rh_milli_pct(rh_milli_pct),
		.crc_ok(crc_ok)
	);

	always #6 clk = ~clk;

	// result side: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(temp_milli_c, rh_milli_pct, crc_ok);
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (stall_requests != stall_served) begin
			stall_served++;
			stall_left = 200;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic start);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte <= d;
		frame_start <= start;
		do @(posedge clk); while (!byte_ready);
		sb.note_byte(d, start);
		byte_transfers++;
	endtask

	task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
			input logic bad_t, input logic bad_h);
		logic [7:0] tc;
		logic [7:0] hc;
		tc = sb.crc_of_word(tw);
		hc = sb.crc_of_word(hw);
		if (bad_t) tc = tc ^ 8'($urandom_range(1, 255));
		if (bad_h) hc = hc ^ 8'($urandom_range(1, 255));
		send_byte(tw[15:8], 1'b1);
		send_byte(tw[7:0], 1'b0);
		send_byte(tc, 1'b0);
		send_byte(hw[15:8], 1'b0);
		send_byte(hw[7:0], 1'b0);
		send_byte(hc, 1'b0);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// mostly whole frames, some stray bytes and cut-short frames
	task automatic run_random_traffic(input int n_bytes);
		int sent;
		int k;
		int r;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send_byte(8'($urandom_range(255)), 1'b0);
				sent++;
			end else if (r < 16) begin
				k = $urandom_range(1, 5);
				send_byte(8'($urandom_range(255)), 1'b1);
				for (int i = 1; i < k; i++) send_byte(8'($urandom_range(255)), 1'b0);
				sent += k;
			end else begin
				send_frame(pick_word(), pick_word(), $urandom_range(99) < 8,
					$urandom_range(99) < 8);
				sent += 6;
			end
		end
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte before any frame, then both word extremes
		send_byte(8'hA5, 1'b0);
		send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0);
		send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);
		// partial frame cut off by a new start, with a bad temperature crc
		send_byte(8'h66, 1'b1);
		send_byte(8'h99, 1'b0);
		send_frame(16'h6666, 16'h8000, 1'b1, 1'b0);
		send_frame(16'h8000, 16'h6666, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0);

		run_random_traffic(170);
		drain();
		src_idle_pct = 78;
		dst_idle_pct <= 6;
		run_random_traffic(170);
		drain();
		src_idle_pct = 0;
		dst_idle_pct <= 0;
		// long receiver hold-off so the pipeline backs up onto the byte input
		stall_requests <= stall_requests + 1;
		run_random_traffic(170);
		drain();
		repeat (10) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("%0d byte transfers, %0d frames with good crc and %0d with bad crc checked",
			byte_transfers, sb.good_frames, sb.bad_frames);
		$display("idling swapped between sides, one long result hold-off, drains between phases");
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout waiting for the decoder");
		$display("FAIL");
		$finish;
	end

endmodule

// ===== humidity_temp_frame_decoder_top.f =====
+incdir+design
design/htfd_pkg.sv
design/htfd_frame.sv
design/htfd_scale.sv
design/humidity_temp_frame_decoder_top.sv
design/htfd_checker.sv
sim/humidity_temp_frame_decoder_top_tb.sv
